FILE: rtl/sha256_pkg.sv
// ----------------------------------------------------------------------------
// sha256_pkg
// types, constants and round functions of the sha-256 message digest
// ----------------------------------------------------------------------------
package sha256_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } sha_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sha_out_t;

  typedef logic [7:0][31:0] hash_t;

  localparam logic [7:0] PadMark   = 8'h80;
  localparam logic [5:0] LengthPos = 6'd56;

  // element 0 is the most significant digest word
  localparam hash_t HashInit = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned s);
    rotr = (v >> s) | (v << (32 - s));
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k;
    case (t)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    round_k = k;
  endfunction

endpackage

FILE: rtl/sha256_message_digest.sv
// ----------------------------------------------------------------------------
// sha256_message_digest
// sha-256 hash of a byte stream, eight digest words per message
// ----------------------------------------------------------------------------
// Message bytes are taken one item per cycle while a block fills. The 64th
// byte of each block starts the compression, which runs one round per cycle
// through a single round unit and a 16-word schedule window, then adds into
// the hash in an add step; no item is accepted during the compression.
// On end of message the padding bytes (0x80, zeros, 64-bit length) are pushed
// one per cycle, followed by one or two compressions and the eight digest
// words, one per cycle as the output side takes them. The block then returns
// to the initial hash values for the next message.
module sha256_message_digest
  import sha256_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  sha_in_t  in_item_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output sha_out_t out_item_o
);

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StPad   = 5'b00010,
    StRound = 5'b00100,
    StAdd   = 5'b01000,
    StOut   = 5'b10000
  } state_e;

  state_e        state_q, state_d;
  hash_t         hash_q, hash_d;
  logic [511:0]  block_q, block_d;
  logic [7:0][31:0] vars_q, vars_d;
  logic [5:0]    fill_q, fill_d;
  logic [63:0]   total_q, total_d;
  logic [5:0]    round_q, round_d;
  logic [2:0]    widx_q, widx_d;
  logic          pad_q, pad_d;
  logic          mark_q, mark_d;
  logic          len_q, len_d;

  logic          push;
  logic [7:0]    push_byte;
  logic [5:0]    fill_inc;
  logic [2:0]    len_sel;
  logic [63:0]   len_shift;
  logic [31:0]   w0, w1, w9, w14, w_new;
  logic [31:0]   t1, t2;
  logic          in_acc, out_acc;

  assign in_stall_o  = (state_q != StIdle);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == StOut);
  assign out_acc     = out_valid_o && !out_stall_i;

  assign out_item_o.digest_word = hash_q[widx_q];
  assign out_item_o.word_index  = widx_q;
  assign out_item_o.last_word   = (widx_q == 3'd7);

  // schedule window: word 0 sits in the top bits
  assign w0  = block_q[511 -: 32];
  assign w1  = block_q[479 -: 32];
  assign w9  = block_q[223 -: 32];
  assign w14 = block_q[63 -: 32];
  assign w_new = w0 + small_sigma0(w1) + w9 + small_sigma1(w14);

  // vars: 0 = a ... 7 = h
  assign t1 = vars_q[7] + big_sigma1(vars_q[4])
            + ((vars_q[4] & vars_q[5]) ^ (~vars_q[4] & vars_q[6]))
            + round_k(round_q) + w0;
  assign t2 = big_sigma0(vars_q[0])
            + ((vars_q[0] & vars_q[1]) ^ (vars_q[0] & vars_q[2])
               ^ (vars_q[1] & vars_q[2]));

  // length bytes go out most significant first at fill 56..63
  assign len_sel   = fill_q[2:0];
  assign len_shift = total_q >> {3'(3'd7 - len_sel), 3'b000};
  assign fill_inc  = fill_q + 6'd1;

  always_comb begin
    push      = 1'b0;
    push_byte = in_item_i.data_byte;
    state_d   = state_q;
    hash_d    = hash_q;
    block_d   = block_q;
    vars_d    = vars_q;
    fill_d    = fill_q;
    total_d   = total_q;
    round_d   = round_q;
    widx_d    = widx_q;
    pad_d     = pad_q;
    mark_d    = mark_q;
    len_d     = len_q;

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          if (in_item_i.has_byte) begin
            push    = 1'b1;
            total_d = total_q + 64'd8;
          end
          if (in_item_i.end_of_message) begin
            pad_d = 1'b1;
            if (!(in_item_i.has_byte && fill_inc == 6'd0)) begin
              state_d = StPad;
            end
          end
        end
      end
      StPad: begin
        push = 1'b1;
        if (!mark_q) begin
          push_byte = PadMark;
          mark_d    = 1'b1;
        end else if (len_q || fill_q == LengthPos) begin
          push_byte = len_shift[7:0];
          len_d     = 1'b1;
        end else begin
          push_byte = 8'h00;
        end
      end
      StRound: begin
        block_d = {block_q[479:0], w_new};
        vars_d  = {vars_q[6:4], vars_q[3] + t1, vars_q[2:0], t1 + t2};
        round_d = round_q + 6'd1;
        if (round_q == 6'd63) begin
          state_d = StAdd;
        end
      end
      StAdd: begin
        for (int i = 0; i < 8; i++) begin
          hash_d[i] = hash_q[i] + vars_q[i];
        end
        if (len_q) begin
          state_d = StOut;
        end else if (pad_q) begin
          state_d = StPad;
        end else begin
          state_d = StIdle;
        end
      end
      StOut: begin
        if (out_acc) begin
          widx_d = widx_q + 3'd1;
          if (widx_q == 3'd7) begin
            state_d = StIdle;
            hash_d  = HashInit;
            total_d = 64'd0;
            fill_d  = 6'd0;
            pad_d   = 1'b0;
            mark_d  = 1'b0;
            len_d   = 1'b0;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    if (push) begin
      block_d = {block_q[503:0], push_byte};
      fill_d  = fill_inc;
      if (fill_inc == 6'd0) begin
        // full block: load a..h from the hash and start the rounds
        state_d = StRound;
        vars_d  = hash_q;
        round_d = 6'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      hash_q  <= HashInit;
      fill_q  <= 6'd0;
      total_q <= 64'd0;
      round_q <= 6'd0;
      widx_q  <= 3'd0;
      pad_q   <= 1'b0;
      mark_q  <= 1'b0;
      len_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      hash_q  <= hash_d;
      fill_q  <= fill_d;
      total_q <= total_d;
      round_q <= round_d;
      widx_q  <= widx_d;
      pad_q   <= pad_d;
      mark_q  <= mark_d;
      len_q   <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    block_q <= block_d;
    vars_q  <= vars_d;
  end

endmodule

FILE: tb/sv/sha256_digest_checker.sv
// ----------------------------------------------------------------------------
// sha256_digest_checker
// watches both channels, predicts the eight digest words of every message and
// compares each word the block delivers against the oldest one predicted
// ----------------------------------------------------------------------------
module sha256_digest_checker
  import sha256_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  sha_in_t     in_item_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  sha_out_t    out_item_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [31:0] word_t;
  typedef word_t [0:7] chain_t;
  typedef word_t [0:15] block_t;

  localparam int unsigned ReportLimit = 10;
  localparam logic [7:0]  PadByte     = 8'h80;
  localparam logic [5:0]  LengthAt    = 6'd56;

  localparam chain_t InitChain = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [0:63][31:0] RoundConst = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // running hash state of the message in flight
  chain_t      chain     = InitChain;
  block_t      msg_block = '0;
  logic [5:0]  fill      = '0;
  logic [63:0] bit_count = '0;

  sha_out_t    expected_digest_words[$];
  int unsigned failures = 0;

  function automatic word_t ror32(input word_t v, input int unsigned s);
    logic [63:0] both;
    both = {v, v} >> s;
    return both[31:0];
  endfunction

  function automatic chain_t compress_block(input chain_t h, input block_t m);
    word_t  sched[64];
    word_t  a, b, c, d, e, f, g, k, t1, t2, x, y;
    chain_t sum;
    int     t;
    for (t = 0; t < 16; t++) sched[t] = m[t];
    for (t = 16; t < 64; t++) begin
      x = sched[t-15];
      y = sched[t-2];
      sched[t] = sched[t-16] + sched[t-7]
               + (ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3))
               + (ror32(y, 17) ^ ror32(y, 19) ^ (y >> 10));
    end
    {a, b, c, d, e, f, g, k} = h;
    for (t = 0; t < 64; t++) begin
      t1 = k + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
         + RoundConst[t] + sched[t];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      k = g;
      g = f;
      f = e;
      e = d + t1;
      d = c;
      c = b;
      b = a;
      a = t1 + t2;
    end
    sum = {a, b, c, d, e, f, g, k};
    for (t = 0; t < 8; t++) sum[t] = sum[t] + h[t];
    return sum;
  endfunction

  task automatic absorb_byte(input logic [7:0] b);
    msg_block[fill[5:2]] = {msg_block[fill[5:2]][23:0], b};
    fill = fill + 6'd1;
    if (fill == 6'd0) chain = compress_block(chain, msg_block);
  endtask

  task automatic finish_message();
    logic [63:0] length_bits;
    sha_out_t    word;
    int          i;
    length_bits = bit_count;
    absorb_byte(PadByte);
    while (fill != LengthAt) absorb_byte(8'h00);
    for (i = 7; i >= 0; i--) absorb_byte(length_bits[i*8 +: 8]);
    for (i = 0; i < 8; i++) begin
      word.digest_word = chain[i];
      word.word_index  = 3'(i);
      word.last_word   = (i == 7);
      expected_digest_words = {expected_digest_words, word};
    end
    chain     = InitChain;
    fill      = '0;
    bit_count = '0;
  endtask

  task automatic take_item(input sha_in_t item);
    if (item.has_byte) begin
      bit_count = bit_count + 64'd8;
      absorb_byte(item.data_byte);
    end
    if (item.end_of_message) finish_message();
  endtask

  task automatic check_word(input sha_out_t got);
    sha_out_t want;
    if (expected_digest_words.size() == 0) begin
      failures++;
      if (failures <= ReportLimit)
        $display("checker: unexpected digest word %h index %0d last %b",
                 got.digest_word, got.word_index, got.last_word);
    end else begin
      want = expected_digest_words.pop_front();
      if (got.digest_word !== want.digest_word || got.word_index !== want.word_index ||
          got.last_word !== want.last_word) begin
        failures++;
        if (failures <= ReportLimit)
          $display("checker: digest mismatch, expected %h/%0d/%b got %h/%0d/%b",
                   want.digest_word, want.word_index, want.last_word,
                   got.digest_word, got.word_index, got.last_word);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain     = InitChain;
      msg_block = '0;
      fill      = '0;
      bit_count = '0;
      expected_digest_words.delete();
    end else begin
      // a word leaving at this edge cannot depend on an item taken at it
      if (out_valid_i && !out_stall_i) check_word(out_item_i);
      if (in_valid_i && !in_stall_i) take_item(in_item_i);
    end
    fail_count_o <= failures;
    pending_o    <= expected_digest_words.size();
  end

endmodule

FILE: tb/sv/tb_sha256_message_digest.sv
// ----------------------------------------------------------------------------
// tb_sha256_message_digest
// byte-stream stimulus for the sha-256 digest block with random idling on
// both channels, one long output hold, and the verdict from the checker
// ----------------------------------------------------------------------------
module tb_sha256_message_digest
  import sha256_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ItemTarget  = 380;
  localparam int unsigned LongHold    = 300;
  localparam int unsigned DrainCycles = 300;
  localparam int unsigned CycleLimit  = 2000000;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  sha_in_t  in_item   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  sha_out_t out_item;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned items_sent  = 0;
  int unsigned cycle_count = 0;
  bit          random_phase = 1'b0;

  always #1 clk = ~clk;

  sha256_message_digest DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  sha256_digest_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_item_i   (out_item),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic sha_in_t make_item(input logic [7:0] data, input logic has,
                                        input logic eom);
    sha_in_t item;
    item.data_byte      = data;
    item.has_byte       = has;
    item.end_of_message = eom;
    return item;
  endfunction

  // mostly back to back, a few short pauses, rarely a long one
  function automatic int unsigned idle_gap(input bit gapless);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (gapless || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic offer_item(input sha_in_t item, input int unsigned gap);
    in_item  <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_message(input int unsigned len, input bit eom_apart);
    bit          gapless;
    int unsigned i;
    gapless = ($urandom_range(0, 3) == 0);
    for (i = 0; i < len; i++) begin
      // ignored filler between bytes
      if ($urandom_range(0, 7) == 0)
        offer_item(make_item(8'($urandom_range(0, 255)), 1'b0, 1'b0), idle_gap(gapless));
      offer_item(make_item(8'($urandom_range(0, 255)), 1'b1, !eom_apart && i == len - 1),
                 idle_gap(gapless));
    end
    if (eom_apart || len == 0)
      offer_item(make_item(8'($urandom_range(0, 255)), 1'b0, 1'b1), idle_gap(gapless));
  endtask

  initial begin : stimulus
    int unsigned pick;
    int unsigned len;
    int unsigned room;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    offer_item(make_item(8'hA5, 1'b0, 1'b0), 0);   // no byte, no end: ignored
    offer_item(make_item(8'h00, 1'b0, 1'b1), 1);   // empty message
    offer_item(make_item(8'h00, 1'b1, 1'b1), 0);
    offer_item(make_item(8'hFF, 1'b1, 1'b0), 2);
    offer_item(make_item(8'h5A, 1'b0, 1'b1), 0);   // end on an item of its own
    offer_item(make_item(8'h61, 1'b1, 1'b0), 0);
    offer_item(make_item(8'h62, 1'b1, 1'b0), 0);
    offer_item(make_item(8'h63, 1'b1, 1'b1), 3);
    offer_item(make_item(8'hFF, 1'b0, 1'b0), 0);

    random_phase = 1'b1;
    // padding fits one block, spills into a second, and follows a full block
    send_message(55, 1'($urandom_range(0, 1)));
    send_message(56, 1'($urandom_range(0, 1)));
    send_message(64, 1'($urandom_range(0, 1)));
    while (items_sent < ItemTarget) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) len = $urandom_range(0, 16);
      else if (pick < 9) len = $urandom_range(17, 70);
      else len = $urandom_range(100, 130);
      // keep the last message from running far past the target
      room = ItemTarget - items_sent;
      if (len > room) len = room;
      send_message(len, 1'($urandom_range(0, 1)));
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : receiver
    int unsigned r;
    int unsigned span;
    int unsigned held;
    bit          hold_done;
    hold_done = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (random_phase && !hold_done && out_valid) begin
        // long hold so the block backs up and stalls its input
        hold_done = 1'b1;
        out_stall <= 1'b1;
        held = 0;
        while (held < LongHold) begin
          @(posedge clk);
          held++;
        end
      end else begin
        r = $urandom_range(0, 99);
        if (r < 40) begin
          out_stall <= 1'b0;
          span = $urandom_range(1, (r < 8) ? 80 : 12);
        end else if (r < 85) begin
          out_stall <= 1'b1;
          span = $urandom_range(1, 3);
        end else if (r < 96) begin
          out_stall <= 1'b1;
          span = $urandom_range(4, 12);
        end else begin
          out_stall <= 1'b1;
          span = $urandom_range(20, 60);
        end
        repeat (span) @(posedge clk);
      end
    end
  end

endmodule

FILE: sim.f
rtl/sha256_pkg.sv
rtl/sha256_message_digest.sv
tb/sv/sha256_digest_checker.sv
tb/sv/tb_sha256_message_digest.sv
